// ----- hw/rtl/sof_length_eof_deframer_defines.svh -----
// assertion macros shared by the deframer checker
// depends on nothing; each macro expands to one labeled concurrent assertion
`ifndef SOF_LENGTH_EOF_DEFRAMER_DEFINES_SVH
`define SOF_LENGTH_EOF_DEFRAMER_DEFINES_SVH

// same-cycle implication, gated by the active-low reset
`define SLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication, gated by the active-low reset
`define SLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// ----- hw/rtl/sle_pkg.sv -----
// shared types and constants for the sof/length/eof deframer
// no dependencies
`default_nettype none

package sle_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD);
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 5;
    localparam int FLAG_W      = 4;
    localparam int STATE_W     = 2;
    localparam int CFG_IDX_W   = 2;

    // length limit compared one bit wider than a byte so 256 still fits
    localparam logic [BYTE_W:0] LEN_LIMIT = (BYTE_W + 1)'(MAX_PAYLOAD);

    localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'hAA;
    localparam logic [BYTE_W-1:0] END_BYTE_RESET   = 8'h55;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 2'd1;

    // receiver state codes as seen on receiver_state
    localparam logic [STATE_W-1:0] ST_WAIT_START = 2'd0;
    localparam logic [STATE_W-1:0] ST_WAIT_LEN   = 2'd1;
    localparam logic [STATE_W-1:0] ST_WAIT_DATA  = 2'd2;
    localparam logic [STATE_W-1:0] ST_WAIT_END   = 2'd3;

    // sticky flag bit positions
    localparam int FLAG_START   = 0;
    localparam int FLAG_LEN_OK  = 1;
    localparam int FLAG_PAYLOAD = 2;
    localparam int FLAG_END     = 3;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] end_byte;
    } cfg_t;

    typedef struct packed {
        logic               payload_valid;
        logic [BYTE_W-1:0]  payload_byte;
        logic [IDX_W-1:0]   payload_index;
        logic               payload_last;
        logic               frame_done;
        logic               length_rejected;
        logic [FLAG_W-1:0]  progress_flags;
        logic [STATE_W-1:0] receiver_state;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sle_cfg_regs.sv -----
// start and end byte configuration registers
// depends on sle_pkg
`default_nettype none

module sle_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [sle_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sle_pkg::BYTE_W-1:0]    cfg_wdata,
    output sle_pkg::cfg_t                      cfg
);
    import sle_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_BYTE: cfg_next.start_byte = cfg_wdata;
                CFG_END_BYTE:   cfg_next.end_byte   = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte <= START_BYTE_RESET;
            cfg_reg.end_byte   <= END_BYTE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sle_in_reg.sv -----
// input register stage for received bytes
// depends on sle_pkg
`default_nettype none

module sle_in_reg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [sle_pkg::BYTE_W-1:0] rx_byte,
    input  wire logic                       advance,
    output logic                            held_valid,
    output logic [sle_pkg::BYTE_W-1:0]      held_byte
);
    import sle_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic              load;

    // stage refills whenever it is empty or its item moves on
    assign load     = !valid_reg || advance;
    assign in_stall = !load;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (load)
        begin
            valid_next = in_valid;
            byte_next  = rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sle_rx_fsm.sv -----
// frame receiver state machine with its result register
// depends on sle_pkg
`default_nettype none

module sle_rx_fsm (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire sle_pkg::cfg_t              cfg,
    input  wire logic                       held_valid,
    input  wire logic [sle_pkg::BYTE_W-1:0] held_byte,
    output logic                            advance,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output sle_pkg::result_t                result
);
    import sle_pkg::*;

    typedef enum logic [STATE_W-1:0] {
        S_WAIT_START = ST_WAIT_START,
        S_WAIT_LEN   = ST_WAIT_LEN,
        S_WAIT_DATA  = ST_WAIT_DATA,
        S_WAIT_END   = ST_WAIT_END
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [LEN_W-1:0]   count_reg;
    logic [LEN_W-1:0]   count_next;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   len_next;
    logic [FLAG_W-1:0]  flags_reg;
    logic [FLAG_W-1:0]  flags_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            result_reg;
    result_t            result_next;
    result_t            res;
    logic [LEN_W:0]     count_inc;
    logic               take;

    assign advance   = !out_valid_reg || !out_stall;
    assign take      = held_valid && advance;
    assign count_inc = {1'b0, count_reg} + (LEN_W + 1)'(1);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        len_next   = len_reg;
        flags_next = flags_reg;
        res        = '0;
        case (state_reg)
            S_WAIT_START:
            begin
                if (held_byte == cfg.start_byte)
                begin
                    state_next             = S_WAIT_LEN;
                    count_next             = '0;
                    flags_next[FLAG_START] = 1'b1;
                end
            end
            S_WAIT_LEN:
            begin
                if ({1'b0, held_byte} >= LEN_LIMIT)
                begin
                    res.length_rejected = 1'b1;
                end
                else
                begin
                    len_next                = LEN_W'(held_byte);
                    count_next              = '0;
                    flags_next[FLAG_LEN_OK] = 1'b1;
                    if (held_byte == '0)
                    begin
                        // empty frame skips the data phase
                        state_next               = S_WAIT_END;
                        flags_next[FLAG_PAYLOAD] = 1'b1;
                    end
                    else
                    begin
                        state_next = S_WAIT_DATA;
                    end
                end
            end
            S_WAIT_DATA:
            begin
                res.payload_valid = 1'b1;
                res.payload_byte  = held_byte;
                res.payload_index = IDX_W'(count_reg);
                count_next        = LEN_W'(count_inc);
                if (count_inc >= {1'b0, len_reg})
                begin
                    res.payload_last         = 1'b1;
                    state_next               = S_WAIT_END;
                    flags_next[FLAG_PAYLOAD] = 1'b1;
                end
            end
            S_WAIT_END:
            begin
                if (held_byte == cfg.end_byte)
                begin
                    res.frame_done         = 1'b1;
                    state_next             = S_WAIT_START;
                    flags_next[FLAG_END]   = 1'b1;
                end
            end
            default:
            begin
                state_next = S_WAIT_START;
            end
        endcase
        res.progress_flags = flags_next;
        res.receiver_state = state_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (advance)
        begin
            out_valid_next = held_valid;
            result_next    = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_WAIT_START;
            count_reg     <= '0;
            len_reg       <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            if (take)
            begin
                state_reg <= state_next;
                count_reg <= count_next;
                len_reg   <= len_next;
                flags_reg <= flags_next;
            end
            out_valid_reg <= out_valid_next;
            result_reg    <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sof_length_eof_deframer.sv -----
// top level of the start/length/payload/end byte deframer
// depends on sle_pkg, sle_cfg_regs, sle_in_reg, sle_rx_fsm
//
//   channel   handshake              payload
//   input     in_valid / in_stall    rx_byte
//   output    out_valid / out_stall  payload_*, frame_done, length_rejected,
//                                    progress_flags, receiver_state
//   config    cfg_we                 cfg_index, cfg_wdata
//
// one byte per cycle sustained while out_stall is low; a byte passes the input register, then the result register
// the frame state updates in the same cycle as the item leaves the input register
// output stall backs up through the input register into in_stall
// rst_n clears the receiver state, flags, valid bits and loads the default bytes
`default_nettype none

module sof_length_eof_deframer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [sle_pkg::BYTE_W-1:0]    rx_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               payload_valid,
    output logic [sle_pkg::BYTE_W-1:0]         payload_byte,
    output logic [sle_pkg::IDX_W-1:0]          payload_index,
    output logic                               payload_last,
    output logic                               frame_done,
    output logic                               length_rejected,
    output logic [sle_pkg::FLAG_W-1:0]         progress_flags,
    output logic [sle_pkg::STATE_W-1:0]        receiver_state,
    input  wire logic                          cfg_we,
    input  wire logic [sle_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sle_pkg::BYTE_W-1:0]    cfg_wdata
);
    import sle_pkg::*;

    cfg_t              cfg;
    result_t           result;
    logic              advance;
    logic              held_valid;
    logic [BYTE_W-1:0] held_byte;

    sle_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sle_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    sle_rx_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result)
    );

    assign payload_valid   = result.payload_valid;
    assign payload_byte    = result.payload_byte;
    assign payload_index   = result.payload_index;
    assign payload_last    = result.payload_last;
    assign frame_done      = result.frame_done;
    assign length_rejected = result.length_rejected;
    assign progress_flags  = result.progress_flags;
    assign receiver_state  = result.receiver_state;

endmodule

`default_nettype wire

// ----- hw/rtl/sle_checker.sv -----
// port-level checks on the deframer, bound to the top level
// depends on sle_pkg and sof_length_eof_deframer_defines.svh
`default_nettype none
`include "sof_length_eof_deframer_defines.svh"

module sle_assert_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic                          payload_valid,
    input  wire logic [sle_pkg::BYTE_W-1:0]    payload_byte,
    input  wire logic [sle_pkg::IDX_W-1:0]     payload_index,
    input  wire logic                          payload_last,
    input  wire logic                          frame_done,
    input  wire logic                          length_rejected,
    input  wire logic [sle_pkg::FLAG_W-1:0]    progress_flags,
    input  wire logic [sle_pkg::STATE_W-1:0]   receiver_state
);
    import sle_pkg::*;

    logic                                     payload_state_ok;
    logic                                     payload_fields_zero;
    logic                                     done_state_ok;
    logic                                     reject_state_ok;
    logic                                     out_stalled;
    logic [BYTE_W+FLAG_W+STATE_W-1:0]         held_fields;

    assign payload_state_ok    = payload_last ? (receiver_state == ST_WAIT_END)
                                              : (receiver_state == ST_WAIT_DATA);
    assign payload_fields_zero = payload_byte == '0 && payload_index == '0 && !payload_last;
    assign done_state_ok       = receiver_state == ST_WAIT_START && progress_flags[FLAG_END]
                                 && !payload_valid;
    assign reject_state_ok     = receiver_state == ST_WAIT_LEN && !payload_valid && !frame_done;
    assign out_stalled         = out_valid && out_stall;
    assign held_fields         = {payload_byte, progress_flags, receiver_state};

    // a payload byte leaves the receiver in data phase, or waiting for end when last
    `SLE_ASSERT_NOW(a_payload_state, clk, rst_n, out_valid && payload_valid, payload_state_ok)

    // non-payload items carry zeroed payload fields
    `SLE_ASSERT_NOW(a_idle_payload_zero, clk, rst_n, out_valid && !payload_valid, payload_fields_zero)

    // a closed frame returns to start hunting and marks the end flag
    `SLE_ASSERT_NOW(a_frame_done_state, clk, rst_n, out_valid && frame_done, done_state_ok)

    // a rejected length keeps the receiver waiting for a length
    `SLE_ASSERT_NOW(a_reject_state, clk, rst_n, out_valid && length_rejected, reject_state_ok)

    // a stalled item stays in place
    `SLE_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_stalled, out_valid && $stable(held_fields))

endmodule

bind sof_length_eof_deframer sle_assert_checker u_sle_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .payload_valid   (payload_valid),
    .payload_byte    (payload_byte),
    .payload_index   (payload_index),
    .payload_last    (payload_last),
    .frame_done      (frame_done),
    .length_rejected (length_rejected),
    .progress_flags  (progress_flags),
    .receiver_state  (receiver_state)
);

`default_nettype wire

// ----- tb/sle_checker.sv -----
// scoreboard for the sof/length/eof deframer: predicts one result per accepted byte
// and compares it with every accepted result; depends on sle_pkg only
`timescale 1ns / 1ps

module sle_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [sle_pkg::BYTE_W-1:0]    rx_byte,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          payload_valid,
    input  logic [sle_pkg::BYTE_W-1:0]    payload_byte,
    input  logic [sle_pkg::IDX_W-1:0]     payload_index,
    input  logic                          payload_last,
    input  logic                          frame_done,
    input  logic                          length_rejected,
    input  logic [sle_pkg::FLAG_W-1:0]    progress_flags,
    input  logic [sle_pkg::STATE_W-1:0]   receiver_state,
    input  logic                          cfg_we,
    input  logic [sle_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sle_pkg::BYTE_W-1:0]    cfg_wdata,
    output int                            fail_count,
    output int                            pending,
    output int                            n_checked,
    output int                            n_payload,
    output int                            n_frames,
    output int                            n_rejected
);

    import sle_pkg::*;

    // receiver copy kept alongside the block
    logic [BYTE_W-1:0]  sof_val;
    logic [BYTE_W-1:0]  eof_val;
    logic [STATE_W-1:0] rx_state;
    logic [8:0]         rx_count;
    logic [IDX_W-1:0]   frame_len;
    logic [FLAG_W-1:0]  flags;

    result_t due_results[$];
    result_t want;

    function automatic result_t deframe_byte(input logic [BYTE_W-1:0] b);
        result_t r;
        r = '0;
        case (rx_state)
            ST_WAIT_START:
                if (b == sof_val)
                begin
                    rx_state = ST_WAIT_LEN;
                    rx_count = '0;
                    flags[FLAG_START] = 1'b1;
                end
            ST_WAIT_LEN:
                if (int'(b) >= MAX_PAYLOAD)
                begin
                    r.length_rejected = 1'b1;
                end
                else
                begin
                    frame_len = b[IDX_W-1:0];
                    rx_count = '0;
                    flags[FLAG_LEN_OK] = 1'b1;
                    if (b == '0)
                    begin
                        // empty frame skips the data state
                        rx_state = ST_WAIT_END;
                        flags[FLAG_PAYLOAD] = 1'b1;
                    end
                    else
                    begin
                        rx_state = ST_WAIT_DATA;
                    end
                end
            ST_WAIT_DATA:
            begin
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                r.payload_index = rx_count[IDX_W-1:0];
                rx_count = rx_count + 9'd1;
                if (rx_count >= {4'd0, frame_len})
                begin
                    r.payload_last = 1'b1;
                    rx_state = ST_WAIT_END;
                    flags[FLAG_PAYLOAD] = 1'b1;
                end
            end
            default:
                if (b == eof_val)
                begin
                    r.frame_done = 1'b1;
                    rx_state = ST_WAIT_START;
                    flags[FLAG_END] = 1'b1;
                end
        endcase
        r.progress_flags = flags;
        r.receiver_state = rx_state;
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            if (fail_count < 10)
                $display("%0t: %s mismatch on result %0d, expected 0x%0h, got 0x%0h",
                         $time, fname, n_checked, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sof_val   = START_BYTE_RESET;
            eof_val   = END_BYTE_RESET;
            rx_state  = ST_WAIT_START;
            rx_count  = '0;
            frame_len = '0;
            flags     = '0;
            due_results.delete();
            fail_count = 0;
            n_checked  = 0;
            n_payload  = 0;
            n_frames   = 0;
            n_rejected = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_START_BYTE)
                    sof_val = cfg_wdata;
                else if (cfg_index == CFG_END_BYTE)
                    eof_val = cfg_wdata;
            end
            // results are matched before this edge's item is queued
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: result arrived with no item outstanding", $time);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("payload_valid", want.payload_valid, payload_valid);
                    check_field("payload_byte", want.payload_byte, payload_byte);
                    check_field("payload_index", want.payload_index, payload_index);
                    check_field("payload_last", want.payload_last, payload_last);
                    check_field("frame_done", want.frame_done, frame_done);
                    check_field("length_rejected", want.length_rejected, length_rejected);
                    check_field("progress_flags", want.progress_flags, progress_flags);
                    check_field("receiver_state", want.receiver_state, receiver_state);
                    n_checked++;
                    n_payload  += want.payload_valid;
                    n_frames   += want.frame_done;
                    n_rejected += want.length_rejected;
                end
            end
            if (in_valid && !in_stall)
                due_results.push_back(deframe_byte(rx_byte));
        end
        pending = due_results.size();
    end

endmodule

// ----- tb/tb.sv -----
// top of the deframer testbench: clock, reset, byte stimulus, register settings
// and the verdict; depends on sle_pkg, sof_length_eof_deframer and sle_checker
`timescale 1ns / 1ps

module tb;

    import sle_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int STUCK_LIMIT = 2000;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 48;
    localparam int N_PHASES    = 5;
    localparam int PHASE_ITEMS = 100;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [BYTE_W-1:0]    rx_byte;
    logic                 out_valid;
    logic                 out_stall;
    logic                 payload_valid;
    logic [BYTE_W-1:0]    payload_byte;
    logic [IDX_W-1:0]     payload_index;
    logic                 payload_last;
    logic                 frame_done;
    logic                 length_rejected;
    logic [FLAG_W-1:0]    progress_flags;
    logic [STATE_W-1:0]   receiver_state;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_wdata;

    int chk_fails;
    int chk_pending;
    int chk_results;
    int chk_payload;
    int chk_frames;
    int chk_rejected;

    int                items_sent;
    bit                tx_idle_en;
    bit                rx_idle_en;
    logic [BYTE_W-1:0] cur_start;
    logic [BYTE_W-1:0] cur_end;

    // strays, rejected lengths, empty frame, payload holding both marker values
    logic [BYTE_W-1:0] opening [25] = '{
        8'h00, 8'hFF, 8'hAA, 8'h20, 8'hFF, 8'hAA, 8'h00, 8'h13, 8'h55,
        8'hAA, 8'h02, 8'h00, 8'hFF, 8'h55,
        8'hAA, 8'h03, 8'h55, 8'hAA, 8'h80, 8'h55,
        8'hAA, 8'h01, 8'h7F, 8'h00, 8'h55
    };

    sof_length_eof_deframer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .payload_valid   (payload_valid),
        .payload_byte    (payload_byte),
        .payload_index   (payload_index),
        .payload_last    (payload_last),
        .frame_done      (frame_done),
        .length_rejected (length_rejected),
        .progress_flags  (progress_flags),
        .receiver_state  (receiver_state),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    sle_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .payload_valid   (payload_valid),
        .payload_byte    (payload_byte),
        .payload_index   (payload_index),
        .payload_last    (payload_last),
        .frame_done      (frame_done),
        .length_rejected (length_rejected),
        .progress_flags  (progress_flags),
        .receiver_state  (receiver_state),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (chk_fails),
        .pending         (chk_pending),
        .n_checked       (chk_results),
        .n_payload       (chk_payload),
        .n_frames        (chk_frames),
        .n_rejected      (chk_rejected)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // offer one item and hold it until accepted; returns at the accepting edge
    task automatic push_byte(input logic [BYTE_W-1:0] b, input bit counted);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 6);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (counted)
            items_sent++;
    endtask

    task automatic send_frame(input bit broken);
        logic [BYTE_W-1:0] b;
        int sel;
        int len;
        int cut;
        int n;
        int i;
        if ($urandom_range(0, 3) == 0)
        begin
            // line noise ahead of the frame
            n = $urandom_range(1, 2);
            for (i = 0; i < n; i++)
            begin
                do b = $urandom; while (b == cur_start);
                push_byte(b, 1'b0);
            end
        end
        push_byte(cur_start, 1'b1);
        if ($urandom_range(0, 4) == 0)
            push_byte(BYTE_W'($urandom_range(MAX_PAYLOAD, 255)), 1'b1);
        sel = $urandom_range(0, 19);
        if (sel == 0)
            len = 0;
        else if (sel == 1)
            len = MAX_PAYLOAD - 1;
        else if (sel <= 4)
            len = $urandom_range(9, MAX_PAYLOAD - 2);
        else
            len = $urandom_range(1, 8);
        push_byte(BYTE_W'(len), 1'b1);
        cut = broken ? $urandom_range(0, len) : len;
        for (i = 0; i < cut; i++)
        begin
            case ($urandom_range(0, 7))
                0:       b = cur_start;
                1:       b = cur_end;
                default: b = $urandom;
            endcase
            push_byte(b, 1'b1);
        end
        // a broken frame leaves the receiver short of its end byte
        if (broken)
            return;
        if ($urandom_range(0, 4) == 0)
        begin
            do b = $urandom; while (b == cur_end);
            push_byte(b, 1'b0);
        end
        push_byte(cur_end, 1'b1);
    endtask

    task automatic wait_idle();
        do @(negedge clk); while (chk_pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // spare indexes go last so a decode slip would clobber the real bytes
    task automatic reprogram(input logic [BYTE_W-1:0] sof, input logic [BYTE_W-1:0] eof);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_START_BYTE;
        cfg_wdata <= sof;
        @(posedge clk);
        cfg_index <= CFG_END_BYTE;
        cfg_wdata <= eof;
        @(posedge clk);
        cfg_index <= CFG_SPARE_A;
        cfg_wdata <= ~sof;
        @(posedge clk);
        cfg_index <= CFG_SPARE_B;
        cfg_wdata <= ~eof;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_start = sof;
        cur_end   = eof;
    endtask

    // output side: random stall bursts plus one long hold-off
    initial
    begin
        int n;
        bit hold_done;
        out_stall = 1'b0;
        hold_done = 1'b0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (!hold_done && items_sent >= HOLD_AT)
            begin
                out_stall <= 1'b1;
                n = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            else if (rx_idle_en && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                n = $urandom_range(1, 6);
            end
            else
            begin
                out_stall <= 1'b0;
                n = $urandom_range(1, 8);
            end
            repeat (n) @(posedge clk);
        end
    end

    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("no progress for %0d cycles", STUCK_LIMIT);
        $display("tb failed");
        $finish;
    end

    initial
    begin
        int p;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        rx_byte    = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_START_BYTE;
        cfg_wdata  = '0;
        items_sent = 0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        cur_start  = START_BYTE_RESET;
        cur_end    = END_BYTE_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (opening[i])
            push_byte(opening[i], 1'b1);

        for (p = 0; p < N_PHASES; p++)
        begin
            if (p != 0)
            begin
                in_valid <= 1'b0;
                wait_idle();
                case (p)
                    1: reprogram(8'h00, 8'hFF);
                    2: reprogram(8'hFF, 8'h00);
                    3: reprogram(8'h05, 8'h05);
                    default:
                    begin
                        tx_idle_en = 1'b0;
                        rx_idle_en = 1'b0;
                        reprogram($urandom, $urandom);
                    end
                endcase
            end
            while (items_sent < 25 + PHASE_ITEMS * (p + 1))
                send_frame($urandom_range(0, 7) == 0);
        end

        in_valid <= 1'b0;
        wait_idle();
        $display("checked %0d results: %0d payload bytes, %0d frames closed",
                 chk_results, chk_payload, chk_frames);
        $display("%0d oversized lengths turned away over %0d register settings",
                 chk_rejected, N_PHASES);
        if (chk_fails == 0 && chk_pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
